### design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Item and result beat structs, entry type, op and status codes.
// No dependencies.
package spq_pkg;

    // Default number of entries held by the store
    localparam int CAPACITY_DEF = 16;

    // Op codes carried by an input beat
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Status codes returned in a result beat
    localparam logic [1:0] ST_ENQUEUED  = 2'd0;
    localparam logic [1:0] ST_DEQUEUED  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic               op;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic signed [31:0] out_priority;
        logic [4:0]         fill_count;
    } t_out_item;

    // One stored entry
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

### design/spq_cell.sv
// One slot of the sorted store: holds an entry, compares it with the
// incoming priority and shifts with its neighbors. Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_valid,      // slot lies below the fill count
    input  t_entry     i_new,        // entry being inserted
    input  t_entry     i_left,       // neighbor toward the head
    input  logic       i_left_gt,    // neighbor would yield to the new entry
    input  t_entry     i_right,      // neighbor toward the tail
    output t_entry     o_entry,
    output logic       o_gt
);

    t_entry r_entry;

    // Empty slots count as larger than anything, so the flag is monotonic
    assign o_gt    = !i_valid || (r_entry.prio > i_new.prio);
    assign o_entry = r_entry;

    // Shift toward the head on remove, toward the tail past the insert point
    always_ff @(posedge i_clk) begin
        if (i_ctrl.del) begin
            r_entry <= i_right;
        end else if (i_ctrl.ins) begin
            if (i_left_gt) begin
                r_entry <= i_left;
            end else if (o_gt) begin
                r_entry <= i_new;
            end
        end
    end

endmodule

### design/sorted_priority_queue_core.sv
// Sorted priority queue, smallest priority first, ties in arrival order.
//
// Input channel: i_in_valid / o_in_stall with one t_in_item per beat.
// An enqueue beat stores item_value and item_priority behind every entry
// of lower or equal priority; a dequeue beat removes the head entry.
// Output channel: o_out_valid / i_out_stall, one t_out_item per input beat,
// carrying status, the removed entry (zero unless dequeued) and the fill
// count after the beat. A full store refuses enqueues with overflow; an
// empty store answers dequeues with underflow.
//
// Every slot is a cell that compares its entry with the incoming priority
// in parallel and shifts with its neighbors: the result appears in the
// cycle after acceptance and, unless the input stalls, one beat is taken
// per cycle. A single output register separates the channels; the input
// stalls only while that register is full and the receiver stalls.
// Reset empties the queue and the output register; no clearing pass.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam t_entry ENTRY_ZERO = '0;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_item     r_out_item;
    t_out_item     n_out_item;

    logic          accept;
    logic          is_deq;
    logic          full;
    logic          empty;
    t_cell_ctrl    ctrl;
    t_entry        new_entry;
    logic [CW+4:0] count_ext;

    t_entry        cell_entry [CAPACITY];
    logic          cell_gt    [CAPACITY];

    // Handshake
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Command decode
    assign is_deq    = (i_in_item.op == OP_DEQ);
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign ctrl      = '{ins: accept && !is_deq && !full, del: accept && is_deq && !empty};
    assign new_entry = '{value: i_in_item.item_value, prio: i_in_item.item_priority};

    // Cell chain, head at index 0
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (ctrl),
            .i_valid   (CW'(gi) < r_count),
            .i_new     (new_entry),
            .i_left    ((gi == 0) ? ENTRY_ZERO : cell_entry[(gi == 0) ? 0 : gi - 1]),
            .i_left_gt ((gi == 0) ? 1'b0 : cell_gt[(gi == 0) ? 0 : gi - 1]),
            .i_right   ((gi == CAPACITY - 1) ? ENTRY_ZERO
                                             : cell_entry[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .o_entry   (cell_entry[gi]),
            .o_gt      (cell_gt[gi])
        );
    end

    // Next count and result beat
    always_comb begin
        n_count = r_count;
        if (ctrl.ins) begin
            n_count = r_count + 1'b1;
        end else if (ctrl.del) begin
            n_count = r_count - 1'b1;
        end
        count_ext = {5'b0, n_count};
        n_out_item = '0;
        n_out_item.fill_count = count_ext[4:0];
        if (is_deq) begin
            if (empty) begin
                n_out_item.status = ST_UNDERFLOW;
            end else begin
                n_out_item.status       = ST_DEQUEUED;
                n_out_item.out_value    = cell_entry[0].value;
                n_out_item.out_priority = cell_entry[0].prio;
            end
        end else begin
            n_out_item.status = full ? ST_OVERFLOW : ST_ENQUEUED;
        end
    end

    // Count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    // Occupancy never exceeds the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    // A removal from a nonempty store drops the count by one
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.del |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not shrink occupancy");

    // A refused enqueue leaves the count alone
    a_ovf_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_deq && full) |=> (r_count == $past(r_count)))
        else $error("overflow changed occupancy");

    // A reported result always matches the count it left behind
    a_result_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid && (r_out_item.fill_count == $past(count_ext[4:0])))
        else $error("accepted beat produced no matching result");

endmodule

### bench/sorted_priority_queue_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_core: directed and random enqueue/dequeue
// beats with random idle gaps and output stalls, checked against a sorted-store model.
// Depends on spq_pkg and sorted_priority_queue_core.
module sorted_priority_queue_core_test;
    import spq_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_item o_out_item;

    // Model of the sorted store, head at index 0
    logic signed [31:0] slot_value [DEPTH];
    logic signed [31:0] slot_prio  [DEPTH];
    int                 slot_count = 0;

    t_out_item expected_results [$];
    t_out_item want;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    int        stall_len;
    bit        no_idle = 1'b0;

    sorted_priority_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none or short, a few long; none at all in burst stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item make_item(input logic op, input logic [31:0] value,
                                           input logic [31:0] prio);
        t_in_item it;
        it.op            = op;
        it.item_value    = value;
        it.item_priority = prio;
        return it;
    endfunction

    // Apply one beat to the store model and return the result it must produce
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item res;
        int        pos;
        res = '0;
        if (it.op == OP_ENQ) begin
            if (slot_count >= DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                // insert behind every entry of lower or equal priority
                pos = slot_count;
                for (int i = 0; i < slot_count; i++) begin
                    if (pos == slot_count && $signed(slot_prio[i]) > $signed(it.item_priority))
                        pos = i;
                end
                for (int i = slot_count; i > pos; i--) begin
                    slot_value[i] = slot_value[i - 1];
                    slot_prio[i]  = slot_prio[i - 1];
                end
                slot_value[pos] = it.item_value;
                slot_prio[pos]  = it.item_priority;
                slot_count++;
                res.status = ST_ENQUEUED;
            end
        end else begin
            if (slot_count == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.status       = ST_DEQUEUED;
                res.out_value    = slot_value[0];
                res.out_priority = slot_prio[0];
                for (int i = 1; i < slot_count; i++) begin
                    slot_value[i - 1] = slot_value[i];
                    slot_prio[i - 1]  = slot_prio[i];
                end
                slot_count--;
            end
        end
        res.fill_count = slot_count[4:0];
        return res;
    endfunction

    // Priority mix: many ties in a narrow band, full range, and the extremes
    function automatic t_in_item random_item(input int enq_pct);
        t_in_item it;
        it.op         = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        it.item_value = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.item_priority = int'($urandom_range(0, 7)) - 4;
            5, 6, 7:       it.item_priority = $urandom;
            8: begin
                case ($urandom_range(0, 3))
                    0:       it.item_priority = 32'h7fff_ffff;
                    1:       it.item_priority = 32'h8000_0000;
                    2:       it.item_priority = 32'h0000_0000;
                    default: it.item_priority = 32'hffff_ffff;
                endcase
            end
            default: it.item_priority = ($urandom_range(0, 1) ? 32'h7fff_fff0 : 32'h8000_0000)
                                        + $urandom_range(0, 15);
        endcase
        return it;
    endfunction

    // Send one beat: optional idle gap, then hold valid until accepted
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_result(it));
    endtask

    // Result side: check accepted beats, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d fill %0d",
                           o_out_item.status, o_out_item.fill_count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                        fail_count++;
                    end
                    if (o_out_item.out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, o_out_item.out_value);
                        fail_count++;
                    end
                    if (o_out_item.out_priority !== want.out_priority) begin
                        $error("out_priority: expected %0d, got %0d",
                               want.out_priority, o_out_item.out_priority);
                        fail_count++;
                    end
                    if (o_out_item.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, o_out_item.fill_count);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_len = pick_gap();
                out_stall <= (stall_len > 0);
                if (stall_len > 0) stall_left = stall_len - 1;
            end
        end
    end

    // Dequeue on an empty store, with junk in the ignored fields
    task automatic test_empty_dequeue();
        send_item(make_item(OP_DEQ, 32'h7fff_ffff, 32'h8000_0000));
    endtask

    // Fill to capacity with extreme and tied priorities, then one refused enqueue
    task automatic test_fill_to_overflow();
        logic [31:0] prios [DEPTH];
        logic [31:0] vals  [DEPTH];
        prios = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'd5, 32'd5, 32'd5,
                  32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_fff9, 32'd3, 32'd3,
                  32'hffff_ffff, 32'd100, 32'h8000_0001};
        vals  = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'd11, 32'd12,
                  32'd13, 32'h5555_aaaa, 32'haaaa_5555, 32'd21, 32'd22, 32'd31, 32'd32,
                  32'd41, 32'd51, 32'd61};
        for (int i = 0; i < DEPTH; i++)
            send_item(make_item(OP_ENQ, vals[i], prios[i]));
        send_item(make_item(OP_ENQ, 32'h8000_0000, 32'h8000_0000));
    endtask

    // Head removals: lowest priorities first, equal ones in arrival order
    task automatic test_ordered_dequeue();
        repeat (6) send_item(make_item(OP_DEQ, $urandom, $urandom));
    endtask

    // Phases biased toward filling, draining or balanced, some without idling
    task automatic test_random_traffic();
        int sent;
        int burst;
        int enq_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            burst   = $urandom_range(10, 60);
            repeat (burst) begin
                send_item(random_item(enq_pct));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sorted_priority_queue_core verification failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_dequeue();
        test_fill_to_overflow();
        test_ordered_dequeue();
        test_random_traffic();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("sorted_priority_queue_core verification clean");
        else
            $display("sorted_priority_queue_core verification failed");
        $finish;
    end

endmodule
